@@ sv/assert_macros.svh @@
// Assertion helpers for the RTL modules; awf_back is the only user.
// No dependencies; take in with `include where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define AWF_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Clocked check that also holds during reset.
`define AWF_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/awf_pkg.sv @@
// Shared constants, operation codes and the queue entry type for the anagram window finder.
// No dependencies; imported by every module of the block.
`default_nettype none

package awf_pkg;

	localparam int ALPHABET      = 26;
	localparam int MAX_PATTERN   = 64;
	localparam int POS_W         = 16;
	localparam int LETTER_W      = 5;
	localparam int KIND_W        = 2;
	localparam int LIDX_W        = $clog2(ALPHABET);
	localparam int COUNT_W       = $clog2(MAX_PATTERN + 1);
	localparam int PTR_W         = $clog2(MAX_PATTERN);
	localparam int DIST_W        = $clog2(ALPHABET + 1);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PATTERN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TEXT    = 2'd2;

	typedef logic [1:0] op_code_t;

	localparam op_code_t OP_CLEAR   = 2'd0;
	localparam op_code_t OP_PATTERN = 2'd1;
	localparam op_code_t OP_TEXT    = 2'd2;

	typedef struct packed {
		op_code_t              code;
		logic                  in_range;
		logic [LETTER_W-1:0]   letter;
	} op_t;

endpackage

`default_nettype wire

@@ sv/anagram_window_finder_top.sv @@
// Anagram window finder: a clear beat starts a query, pattern letter beats load
// per-letter counts, and text letter beats slide a window that is checked for an
// anagram of the pattern.
// Input channel item_valid/item_stall carries kind and letter; the output channel
// match_valid/match_stall carries one beat per found window with its start and end
// text positions. Windows never overlap: a match empties the window.
// Clear and pattern beats, and text letters that drop nothing, are done in idle;
// a text letter that drops k old letters from the window passes the shrink state
// for them and then the finish state; each text letter is dropped at most once.
// The drop loop reads one window entry a cycle from the ring memory.
// Input beats pass the front register and the two-entry queue to the back end.
// Reset clears all counts, the pattern and the text position; no clearing pass.
// While match_stall holds a result, the back end finishes no further text letter;
// the two-entry queue and the front register still take up to three beats.
// Depends on awf_pkg, awf_front, awf_queue and awf_back.
`default_nettype none

module anagram_window_finder_top import awf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [LETTER_W-1:0] letter,
	output logic                     match_valid,
	input  wire logic                match_stall,
	output logic                     match_found,
	output logic [POS_W-1:0]         match_start,
	output logic [POS_W-1:0]         match_end
);

	logic push;
	op_t  push_op;
	logic full;
	logic pop;
	logic op_valid;
	op_t  op;

	awf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.letter     (letter),
		.full       (full),
		.push       (push),
		.push_op    (push_op)
	);

	awf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.full     (full),
		.pop      (pop),
		.op_valid (op_valid),
		.op       (op)
	);

	awf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (op_valid),
		.op          (op),
		.pop         (pop),
		.match_valid (match_valid),
		.match_stall (match_stall),
		.match_found (match_found),
		.match_start (match_start),
		.match_end   (match_end)
	);

endmodule

`default_nettype wire

@@ sv/awf_front.sv @@
// Front stage: accepts input beats, classifies them and hands them to the queue.
// Depends on awf_pkg.
`default_nettype none

module awf_front import awf_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [LETTER_W-1:0] letter,
	input  wire logic                full,
	output logic                     push,
	output op_t                      push_op
);

	logic valid_s1;
	op_t  op_s1;
	op_t  op_next;
	logic keep;
	logic accept;

	assign item_stall = valid_s1 && full;
	assign accept     = item_valid && !item_stall;
	assign push       = valid_s1 && !full;
	assign push_op    = op_s1;

	always_comb begin
		op_next.letter   = letter;
		op_next.in_range = (letter < LETTER_W'(ALPHABET));
		keep             = 1'b1;
		unique case (kind)
			KIND_CLEAR:   op_next.code = OP_CLEAR;
			KIND_PATTERN: op_next.code = OP_PATTERN;
			KIND_TEXT:    op_next.code = OP_TEXT;
			default: begin
				// unused kind: drop the beat
				op_next.code = OP_CLEAR;
				keep         = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (!full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_next;
		end
	end

endmodule

`default_nettype wire

@@ sv/awf_queue.sv @@
// Two-entry queue of classified operations between the front and back stages.
// Depends on awf_pkg.
`default_nettype none

module awf_queue import awf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  op_t       push_op,
	output logic      full,
	input  wire logic pop,
	output logic      op_valid,
	output op_t       op
);

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign op_valid = (count_q != '0);
	assign op       = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && op_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

@@ sv/awf_back.sv @@
// Back stage: letter counts, window ring memory, shrink sequencer and result register.
// Depends on awf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module awf_back import awf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             op_valid,
	input  op_t                   op,
	output logic                  pop,
	output logic                  match_valid,
	input  wire logic             match_stall,
	output logic                  match_found,
	output logic [POS_W-1:0]      match_start,
	output logic [POS_W-1:0]      match_end
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_POP  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]          state_q;
	logic [COUNT_W-1:0]  pc_q [ALPHABET];
	logic [COUNT_W-1:0]  wc_q [ALPHABET];
	logic [LIDX_W-1:0]   win_mem [MAX_PATTERN];
	logic [LIDX_W-1:0]   rd_q;
	logic [PTR_W-1:0]    head_q;
	logic [COUNT_W-1:0]  len_q;
	logic [COUNT_W-1:0]  plen_q;
	logic [DIST_W-1:0]   dist_q;
	logic [DIST_W-1:0]   matched_q;
	logic [POS_W-1:0]    tpos_q;
	logic [POS_W-1:0]    cur_pos_q;
	logic [LIDX_W-1:0]   cur_q;
	logic                valid_q;
	logic [POS_W-1:0]    start_q;
	logic [POS_W-1:0]    end_q;

	logic                out_free;
	logic                take;
	logic [LIDX_W-1:0]   idx;
	logic                text_hit;
	logic [COUNT_W-1:0]  wc_inc;
	logic                need_pop;

	logic                in_fin;
	logic [LIDX_W-1:0]   fin_idx;
	logic [COUNT_W-1:0]  fin_wc;
	logic [POS_W-1:0]    fin_pos;
	logic                fin_room;
	logic [COUNT_W-1:0]  fin_len;
	logic [PTR_W:0]      tail_sum;
	logic [PTR_W-1:0]    tail;
	logic [DIST_W-1:0]   fin_matched;
	logic                fin_hit;
	logic                do_finish;
	logic                push_en;

	logic [LIDX_W-1:0]   old;
	logic [COUNT_W-1:0]  wc_old;
	logic [COUNT_W-1:0]  wc_old_new;
	logic                dec;
	logic [PTR_W-1:0]    head_next;
	logic [COUNT_W-1:0]  len_dec;
	logic [COUNT_W-1:0]  cur_after;
	logic                pop_more;
	logic [PTR_W-1:0]    rd_addr;

	assign out_free = !valid_q || !match_stall;
	assign take     = (state_q == ST_IDLE) && op_valid && out_free;
	assign pop      = take;

	// idle: classify the head operation
	assign idx      = op.in_range ? op.letter[LIDX_W-1:0] : '0;
	assign text_hit = op.in_range && (pc_q[idx] != '0);
	assign wc_inc   = wc_q[idx] + 1'b1;
	assign need_pop = (len_q != '0) && (wc_inc > pc_q[idx]);

	// finish: push the letter and test for a full match
	assign in_fin      = (state_q == ST_FIN);
	assign fin_idx     = in_fin ? cur_q : idx;
	assign fin_wc      = in_fin ? wc_q[cur_q] : wc_inc;
	assign fin_pos     = in_fin ? cur_pos_q : tpos_q;
	assign fin_room    = (len_q < COUNT_W'(MAX_PATTERN));
	assign fin_len     = len_q + COUNT_W'(fin_room);
	assign tail_sum    = {1'b0, head_q} + (PTR_W + 1)'(len_q[PTR_W-1:0]);
	assign tail        = (tail_sum >= (PTR_W + 1)'(MAX_PATTERN))
	                     ? PTR_W'(tail_sum - (PTR_W + 1)'(MAX_PATTERN)) : tail_sum[PTR_W-1:0];
	assign fin_matched = matched_q + DIST_W'(fin_wc == pc_q[fin_idx]);
	assign fin_hit     = (dist_q != '0) && (fin_matched == dist_q);
	assign do_finish   = (take && (op.code == OP_TEXT) && text_hit && !need_pop)
	                     || (in_fin && out_free);
	assign push_en     = do_finish && fin_room;

	// shrink: drop the oldest window letter
	assign old        = rd_q;
	assign wc_old     = wc_q[old];
	assign dec        = (wc_old >= pc_q[old]) && (matched_q != '0);
	assign wc_old_new = (wc_old != '0) ? wc_old - 1'b1 : wc_old;
	assign head_next  = (head_q == PTR_W'(MAX_PATTERN - 1)) ? '0 : head_q + 1'b1;
	assign len_dec    = len_q - 1'b1;
	assign cur_after  = (old == cur_q) ? wc_old_new : wc_q[cur_q];
	assign pop_more   = (len_dec != '0) && (cur_after > pc_q[cur_q]);
	assign rd_addr    = (state_q == ST_POP) ? head_next : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			for (int i = 0; i < ALPHABET; i++) begin
				pc_q[i] <= '0;
				wc_q[i] <= '0;
			end
			head_q    <= '0;
			len_q     <= '0;
			plen_q    <= '0;
			dist_q    <= '0;
			matched_q <= '0;
			tpos_q    <= '0;
			cur_q     <= '0;
			cur_pos_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (op.code)
							OP_CLEAR: begin
								for (int i = 0; i < ALPHABET; i++) begin
									pc_q[i] <= '0;
									wc_q[i] <= '0;
								end
								head_q    <= '0;
								len_q     <= '0;
								plen_q    <= '0;
								dist_q    <= '0;
								matched_q <= '0;
								tpos_q    <= '0;
							end
							OP_PATTERN: begin
								for (int i = 0; i < ALPHABET; i++) begin
									wc_q[i] <= '0;
								end
								head_q    <= '0;
								len_q     <= '0;
								matched_q <= '0;
								if (op.in_range && (plen_q < COUNT_W'(MAX_PATTERN))) begin
									if (pc_q[idx] == '0) begin
										dist_q <= dist_q + 1'b1;
									end
									pc_q[idx] <= pc_q[idx] + 1'b1;
									plen_q    <= plen_q + 1'b1;
								end
							end
							OP_TEXT: begin
								tpos_q <= tpos_q + 1'b1;
								if (!text_hit || (do_finish && fin_hit)) begin
									for (int i = 0; i < ALPHABET; i++) begin
										wc_q[i] <= '0;
									end
									head_q    <= '0;
									len_q     <= '0;
									matched_q <= '0;
								end else if (need_pop) begin
									wc_q[idx] <= wc_inc;
									cur_q     <= idx;
									cur_pos_q <= tpos_q;
									state_q   <= ST_POP;
								end else begin
									wc_q[idx] <= wc_inc;
									matched_q <= fin_matched;
									len_q     <= fin_len;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					wc_q[old] <= wc_old_new;
					matched_q <= matched_q - DIST_W'(dec);
					head_q    <= head_next;
					len_q     <= len_dec;
					if (!pop_more) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						if (fin_hit) begin
							for (int i = 0; i < ALPHABET; i++) begin
								wc_q[i] <= '0;
							end
							head_q    <= '0;
							len_q     <= '0;
							matched_q <= '0;
						end else begin
							matched_q <= fin_matched;
							len_q     <= fin_len;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window ring: write the tail, read ahead of the head
	always_ff @(posedge clk) begin
		if (push_en) begin
			win_mem[tail] <= fin_idx;
		end
		rd_q <= win_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_finish && fin_hit) begin
			valid_q <= 1'b1;
		end else if (!match_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_finish && fin_hit) begin
			start_q <= fin_pos - POS_W'(fin_len) + 1'b1;
			end_q   <= fin_pos;
		end
	end

	assign match_valid = valid_q;
	assign match_found = 1'b1;
	assign match_start = start_q;
	assign match_end   = end_q;

	`AWF_ASSERT(a_len_bound, clk, arst_n, len_q <= COUNT_W'(MAX_PATTERN), "window overran")
	`AWF_ASSERT(a_matched_bound, clk, arst_n, matched_q <= dist_q, "matched exceeds needed")
	`AWF_ASSERT(a_pop_nonempty, clk, arst_n, (state_q == ST_POP) |-> (len_q != '0), "shrink on empty window")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for anagram_window_finder_top: directed, overflow and random
// query streams, with an in-bench window predictor and random idling on both channels.
// Depends on awf_pkg and the anagram_window_finder_top RTL.
module testbench import awf_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  RANDOM_ITEMS = 1400;
	localparam int  END_TAIL     = 80;
	localparam int  CYCLE_LIMIT  = 1000000;

	// the block ignores this kind entirely
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam logic [LETTER_W-1:0] LTR_A   = 5'd0;
	localparam logic [LETTER_W-1:0] LTR_B   = 5'd1;
	localparam logic [LETTER_W-1:0] LTR_C   = 5'd2;
	localparam logic [LETTER_W-1:0] LTR_D   = 5'd3;
	localparam logic [LETTER_W-1:0] LTR_Z   = 5'd25;
	localparam logic [LETTER_W-1:0] LTR_BAD = 5'd30;
	localparam logic [LETTER_W-1:0] LTR_MAX = 5'd31;

	typedef struct {
		logic             found;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] finish;
	} match_rec_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                item_valid  = 1'b0;
	logic                item_stall;
	logic [KIND_W-1:0]   kind        = KIND_CLEAR;
	logic [LETTER_W-1:0] letter      = LTR_A;
	logic                match_valid;
	logic                match_stall = 1'b0;
	logic                match_found;
	logic [POS_W-1:0]    match_start;
	logic [POS_W-1:0]    match_end;

	int         error_count  = 0;
	int         cycle_count  = 0;
	bit         idle_enable  = 1'b1;
	bit         stall_enable = 1'b1;
	int         burst_left   = 0;
	int         stall_left   = 0;
	bit         stall_phase  = 1'b0;
	match_rec_t pending_matches[$];

	// predictor state
	logic [COUNT_W-1:0]  pat_cnt [ALPHABET];
	logic [COUNT_W-1:0]  win_cnt [ALPHABET];
	logic [LETTER_W-1:0] win_ring [MAX_PATTERN];
	logic [PTR_W-1:0]    win_head;
	logic [COUNT_W-1:0]  win_len;
	logic [COUNT_W-1:0]  pat_len;
	logic [DIST_W-1:0]   distinct_cnt;
	logic [DIST_W-1:0]   matched_cnt;
	logic [POS_W-1:0]    text_pos;

	anagram_window_finder_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.kind        (kind),
		.letter      (letter),
		.match_valid (match_valid),
		.match_stall (match_stall),
		.match_found (match_found),
		.match_start (match_start),
		.match_end   (match_end)
	);

	always #5 clk = ~clk;

	function automatic void clear_window();
		for (int i = 0; i < ALPHABET; i++)
			win_cnt[i] = '0;
		win_head    = '0;
		win_len     = '0;
		matched_cnt = '0;
	endfunction

	function automatic void clear_query();
		for (int i = 0; i < ALPHABET; i++)
			pat_cnt[i] = '0;
		for (int i = 0; i < MAX_PATTERN; i++)
			win_ring[i] = '0;
		clear_window();
		pat_len      = '0;
		distinct_cnt = '0;
		text_pos     = '0;
	endfunction

	// advance the window model by one accepted beat and queue any match it completes
	function automatic void predict_window(input logic [KIND_W-1:0] k,
			input logic [LETTER_W-1:0] l);
		logic [POS_W-1:0]    pos;
		logic [POS_W-1:0]    len_ext;
		logic [LETTER_W-1:0] oldest;
		logic [PTR_W-1:0]    tail;
		match_rec_t          rec;
		case (k)
		KIND_CLEAR: begin
			clear_query();
		end
		KIND_PATTERN: begin
			clear_window();
			if (l < ALPHABET && pat_len < MAX_PATTERN) begin
				if (pat_cnt[l] == 0)
					distinct_cnt = distinct_cnt + 1'b1;
				pat_cnt[l] = pat_cnt[l] + 1'b1;
				pat_len    = pat_len + 1'b1;
			end
		end
		KIND_TEXT: begin
			pos      = text_pos;
			text_pos = pos + 1'b1;
			if (l >= ALPHABET || pat_cnt[l] == 0) begin
				clear_window();
			end else begin
				win_cnt[l] = win_cnt[l] + 1'b1;
				// drop oldest letters until this letter fits its pattern count
				while (win_len > 0 && win_cnt[l] > pat_cnt[l]) begin
					oldest = win_ring[win_head];
					if (oldest < ALPHABET) begin
						if (win_cnt[oldest] >= pat_cnt[oldest] && matched_cnt > 0)
							matched_cnt = matched_cnt - 1'b1;
						if (win_cnt[oldest] > 0)
							win_cnt[oldest] = win_cnt[oldest] - 1'b1;
					end
					win_head = win_head + 1'b1;
					win_len  = win_len - 1'b1;
				end
				if (win_len < MAX_PATTERN) begin
					tail           = win_head + win_len[PTR_W-1:0];
					win_ring[tail] = l;
					win_len        = win_len + 1'b1;
				end
				if (win_cnt[l] == pat_cnt[l])
					matched_cnt = matched_cnt + 1'b1;
				if (distinct_cnt > 0 && matched_cnt == distinct_cnt) begin
					len_ext    = POS_W'(win_len);
					rec.found  = 1'b1;
					rec.start  = pos - len_ext + 1'b1;
					rec.finish = pos;
					pending_matches.insert(pending_matches.size(), rec);
					clear_window();
				end
			end
		end
		default: begin
		end
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idle_enable)
			return 0;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(50, 150);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [LETTER_W-1:0] l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		letter     <= l;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_window(k, l);
		@(negedge clk);
	endtask

	// hold the sender until every queued match has come out
	task automatic wait_for_matches(input int tail_cycles);
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_matches.size() != 0)
			@(negedge clk);
		repeat (tail_cycles) @(negedge clk);
	endtask

	task automatic test_basic_match();
		send_item(KIND_CLEAR, LTR_A);
		send_item(KIND_PATTERN, LTR_A);
		send_item(KIND_PATTERN, LTR_B);
		send_item(KIND_PATTERN, LTR_Z);
		send_item(KIND_TEXT, LTR_Z);
		send_item(KIND_TEXT, LTR_B);
		send_item(KIND_TEXT, LTR_A);
		send_item(KIND_TEXT, LTR_A);
		send_item(KIND_TEXT, LTR_Z);
		send_item(KIND_TEXT, LTR_B);
		wait_for_matches(0);
	endtask

	task automatic test_odd_items();
		send_item(KIND_UNUSED, LTR_MAX);
		send_item(KIND_TEXT, LTR_MAX);
		send_item(KIND_PATTERN, LTR_BAD);
		send_item(KIND_TEXT, LTR_A);
		send_item(KIND_TEXT, LTR_A);
		send_item(KIND_TEXT, LTR_B);
		send_item(KIND_TEXT, LTR_Z);
		wait_for_matches(0);
	endtask

	task automatic test_empty_pattern();
		send_item(KIND_CLEAR, LTR_MAX);
		send_item(KIND_TEXT, LTR_A);
		send_item(KIND_TEXT, LTR_Z);
		send_item(KIND_TEXT, LTR_MAX);
		wait_for_matches(0);
	endtask

	// fill the pattern past capacity, then match a window of full length
	task automatic test_pattern_overflow();
		send_item(KIND_CLEAR, LTR_A);
		repeat (MAX_PATTERN - 1) send_item(KIND_PATTERN, LTR_A);
		send_item(KIND_PATTERN, LTR_B);
		send_item(KIND_PATTERN, LTR_C);
		send_item(KIND_PATTERN, LTR_D);
		send_item(KIND_TEXT, LTR_C);
		repeat (MAX_PATTERN - 1) send_item(KIND_TEXT, LTR_A);
		send_item(KIND_TEXT, LTR_B);
		send_item(KIND_TEXT, LTR_B);
		send_item(KIND_TEXT, LTR_A);
		wait_for_matches(0);
	endtask

	task automatic test_random_queries(input int n_items);
		logic [LETTER_W-1:0] query_letters[$];
		logic [LETTER_W-1:0] perm[$];
		logic [LETTER_W-1:0] l;
		logic [LETTER_W-1:0] tmp;
		int                  sent;
		int                  span;
		int                  base;
		int                  plen;
		int                  text_len;
		int                  r;
		int                  j;
		sent = 0;
		while (sent < n_items) begin
			span = $urandom_range(1, 6);
			base = $urandom_range(0, ALPHABET - span);
			plen = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
			if ($urandom_range(0, 4) != 0) begin
				l = LETTER_W'($urandom_range(0, 31));
				send_item(KIND_CLEAR, l);
				sent++;
				query_letters.delete();
			end
			for (int i = 0; i < plen; i++) begin
				if ($urandom_range(0, 9) == 0)
					l = LETTER_W'($urandom_range(ALPHABET, 31));
				else
					l = LETTER_W'(base + $urandom_range(0, span - 1));
				send_item(KIND_PATTERN, l);
				sent++;
				if (l < ALPHABET && query_letters.size() < MAX_PATTERN)
					query_letters.insert(query_letters.size(), l);
			end
			text_len = $urandom_range(10, 80);
			for (int t = 0; t < text_len; t++) begin
				r = $urandom_range(0, 99);
				if (r < 40 && query_letters.size() > 0) begin
					perm = query_letters;
					for (int i = perm.size() - 1; i > 0; i--) begin
						j       = $urandom_range(0, i);
						tmp     = perm[i];
						perm[i] = perm[j];
						perm[j] = tmp;
					end
					foreach (perm[i]) begin
						send_item(KIND_TEXT, perm[i]);
						sent++;
					end
				end else if (r < 70 && query_letters.size() > 0) begin
					l = query_letters[$urandom_range(0, query_letters.size() - 1)];
					send_item(KIND_TEXT, l);
					sent++;
				end else if (r < 85) begin
					l = LETTER_W'(base + $urandom_range(0, span - 1));
					send_item(KIND_TEXT, l);
					sent++;
				end else if (r < 90) begin
					l = LETTER_W'($urandom_range(ALPHABET, 31));
					send_item(KIND_TEXT, l);
					sent++;
				end else if (r < 94) begin
					l = LETTER_W'($urandom_range(0, 31));
					send_item(KIND_TEXT, l);
					sent++;
				end else if (r < 96) begin
					l = LETTER_W'($urandom_range(0, 31));
					send_item(KIND_UNUSED, l);
				end else if (r < 98) begin
					l = LETTER_W'(base + $urandom_range(0, span - 1));
					send_item(KIND_PATTERN, l);
					sent++;
					if (query_letters.size() < MAX_PATTERN)
						query_letters.insert(query_letters.size(), l);
				end else begin
					wait_for_matches(0);
				end
			end
		end
	endtask

	// receiver: alternate stall and free stretches, mostly short
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_phase = !stall_phase;
			if (stall_phase)
				stall_left = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 3) :
					($urandom_range(0, 99) < 85) ? $urandom_range(4, 10) :
					$urandom_range(20, 40);
			else
				stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) :
					$urandom_range(40, 150);
		end
		stall_left--;
		match_stall <= stall_phase && stall_enable;
	end

	always @(posedge clk) begin
		match_rec_t want;
		if (arst_n && match_valid && !match_stall) begin
			if (pending_matches.size() == 0) begin
				$error("unexpected match beat: start %0d end %0d", match_start, match_end);
				error_count++;
			end else begin
				want = pending_matches.pop_front();
				if (match_found !== want.found) begin
					$error("match_found: expected %0d, got %0d", want.found, match_found);
					error_count++;
				end
				if (match_start !== want.start) begin
					$error("match_start: expected %0d, got %0d", want.start, match_start);
					error_count++;
				end
				if (match_end !== want.finish) begin
					$error("match_end: expected %0d, got %0d", want.finish, match_end);
					error_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		clear_query();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_match();
		test_odd_items();
		test_empty_pattern();
		test_pattern_overflow();
		test_random_queries(RANDOM_ITEMS);
		wait_for_matches(END_TAIL);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/awf_pkg.sv
sv/awf_front.sv
sv/awf_queue.sv
sv/awf_back.sv
sv/anagram_window_finder_top.sv
dv/testbench.sv
